// ===== design/lsa_pkg.sv =====
// ----------------------------------------------------------------------------
// Latency statistics package
// Widths, constants and payload types shared by the latency statistics block.
// ----------------------------------------------------------------------------
package lsa_pkg;

	// Field widths
	localparam int SEC_W  = 32;
	localparam int US_W   = 20;
	localparam int LAT_W  = 48;
	localparam int FRAC_W = 8;
	localparam int MEAN_W = LAT_W + FRAC_W;
	localparam int CNT_W  = 32;

	// Signed seconds difference, and the working width of the shared adder.
	// The accumulator holds mean * (n - 1) + latency * 2^FRAC_W, which stays
	// below 2^(MEAN_W + CNT_W); one spare bit keeps the sign during latency.
	localparam int DSEC_W = SEC_W + 1;
	localparam int ACC_W  = MEAN_W + CNT_W + 1;
	localparam int REM_W  = CNT_W;

	// Sequencer step counter and bit-select widths
	localparam int STEP_W    = $clog2(ACC_W);
	localparam int US_IDX_W  = $clog2(US_W);
	localparam int CNT_IDX_W = $clog2(CNT_W);

	localparam logic [US_W-1:0]  US_PER_S = US_W'(1000000);
	localparam logic [CNT_W-1:0] CNT_MAX  = '1;
	localparam logic [LAT_W-1:0] LAT_MAX  = '1;

	// One observation
	typedef struct packed {
		logic [SEC_W-1:0] begin_seconds;
		logic [US_W-1:0]  begin_micros;
		logic [SEC_W-1:0] end_seconds;
		logic [US_W-1:0]  end_micros;
	} obs_t;

	// One result
	typedef struct packed {
		logic [LAT_W-1:0]  sample_latency;
		logic [CNT_W-1:0]  observation_count;
		logic [MEAN_W-1:0] mean_latency_q8;
		logic [LAT_W-1:0]  min_latency;
		logic [LAT_W-1:0]  max_latency;
		logic              went_backwards;
		logic              clipped_high;
	} stat_t;

	// Request to the shared adder
	typedef struct packed {
		logic [ACC_W-1:0] a;
		logic [ACC_W-1:0] b;
		logic             sub;
	} alu_req_t;

	// Response from the shared adder; carry is "a >= b" on a subtract.
	typedef struct packed {
		logic [ACC_W-1:0] sum;
		logic             carry;
	} alu_rsp_t;

endpackage

// ===== design/latency_stats_accumulator.sv =====
// ----------------------------------------------------------------------------
// Latency statistics accumulator
// Turns start/stop timestamps into a clamped latency in microseconds and keeps
// a saturating count, a Q.8 running mean, and the minimum and maximum.
//
//   Channel  Direction  Handshake             Payload
//   obs      in         obs_valid, obs_stall  obs_data  (obs_t)
//   stat     out        stat_valid, stat_stall stat_data (stat_t)
//
// An observation is accepted only while the sequencer is idle, so the block
// does not take a new one until the last has reached the output register.
// The sequencer makes bit-serial passes through the shared 89-bit adder:
// 20 steps to scale seconds by one million, 32 for the multiply and 89 for
// the divide of the mean update.
// Reset clears the count, mean and maximum and sets the minimum to all ones.
// A finished result sits in an output register; the next observation is
// accepted while it waits, and a stalled result holds the sequencer at its end.
// ----------------------------------------------------------------------------
module latency_stats_accumulator
	import lsa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  obs_valid,
	output logic  obs_stall,
	input  obs_t  obs_data,
	output logic  stat_valid,
	input  logic  stat_stall,
	output stat_t stat_data
);

	logic  seq_ready;
	logic  seq_valid;
	logic  seq_take;
	stat_t seq_res;
	logic  vld_q;
	stat_t stat_q;

	lsa_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.obs_valid (obs_valid),
		.obs       (obs_data),
		.ready     (seq_ready),
		.res_valid (seq_valid),
		.res_ready (seq_take),
		.res       (seq_res)
	);

	assign obs_stall = !seq_ready;

	// The output register is free when empty or when its transfer completes.
	assign seq_take = !vld_q || !stat_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (seq_valid && seq_take) begin
			vld_q <= 1'b1;
		end else if (!stat_stall) begin
			vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_valid && seq_take) begin
			stat_q <= seq_res;
		end
	end

	assign stat_valid = vld_q;
	assign stat_data  = stat_q;

`ifndef SYNTHESIS
	// A latency is never both clamped low and saturated high.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid |-> !(stat_data.went_backwards && stat_data.clipped_high))
		else $error("latency_stats_accumulator: both clamp flags set");

	// The mean never exceeds the largest latency seen.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid |-> (stat_data.mean_latency_q8 <=
			{stat_data.max_latency, {FRAC_W{1'b0}}}))
		else $error("latency_stats_accumulator: mean above maximum");

	// Every result counts at least its own observation.
	assert property (@(posedge clk) disable iff (!arst_n)
		stat_valid |-> (stat_data.observation_count != '0))
		else $error("latency_stats_accumulator: result with zero count");
`endif

endmodule

// ===== design/lsa_alu.sv =====
// ----------------------------------------------------------------------------
// Latency statistics shared adder
// One wide add or subtract with carry out, used by every arithmetic state of the sequencer.
// ----------------------------------------------------------------------------
module lsa_alu
	import lsa_pkg::*;
(
	input  alu_req_t req,
	output alu_rsp_t rsp
);

	logic [ACC_W-1:0] b_eff;
	logic [ACC_W:0]   total;

	// A subtract adds the inverted operand plus one.
	assign b_eff = req.sub ? ~req.b : req.b;
	assign total = {1'b0, req.a} + {1'b0, b_eff} + {{ACC_W{1'b0}}, req.sub};

	assign rsp.sum   = total[ACC_W-1:0];
	assign rsp.carry = total[ACC_W];

endmodule

// ===== design/lsa_seq.sv =====
// ----------------------------------------------------------------------------
// Latency statistics sequencer
// Steps one observation through the shared adder: latency, clamping,
// statistics update, bit-serial multiply and restoring divide for the mean.
// ----------------------------------------------------------------------------
module lsa_seq
	import lsa_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  obs_valid,
	input  obs_t  obs,
	output logic  ready,
	output logic  res_valid,
	input  logic  res_ready,
	output stat_t res
);

	typedef enum logic [10:0] {
		ST_IDLE  = 11'b000_0000_0001,
		ST_SUBS  = 11'b000_0000_0010,
		ST_MULK  = 11'b000_0000_0100,
		ST_ADDU  = 11'b000_0000_1000,
		ST_SUBU  = 11'b000_0001_0000,
		ST_CLAMP = 11'b000_0010_0000,
		ST_MULM  = 11'b000_0100_0000,
		ST_ADDL  = 11'b000_1000_0000,
		ST_DIV   = 11'b001_0000_0000,
		ST_FIN   = 11'b010_0000_0000,
		ST_DONE  = 11'b100_0000_0000
	} state_t;

	state_t              state_q;
	logic [STEP_W-1:0]   step_q;
	logic [CNT_W-1:0]    cnt_q;
	logic [MEAN_W-1:0]   mean_q;
	logic [LAT_W-1:0]    min_q;
	logic [LAT_W-1:0]    max_q;

	obs_t                obs_q;
	logic [ACC_W-1:0]    acc_q;
	logic [REM_W-1:0]    rem_q;
	logic [DSEC_W-1:0]   dsec_q;
	logic [CNT_W-1:0]    mplier_q;
	logic [LAT_W-1:0]    lat_q;
	logic                back_q;
	logic                clip_q;

	alu_req_t            alu_req;
	alu_rsp_t            alu_rsp;

	logic                lat_neg;
	logic                lat_big;
	logic [LAT_W-1:0]    lat_c;
	logic                step_last;
	logic [REM_W:0]      rem_shift;

	lsa_alu u_alu (
		.req (alu_req),
		.rsp (alu_rsp)
	);

	// Clamp the signed latency held in the accumulator.
	assign lat_neg   = acc_q[ACC_W-1];
	assign lat_big   = !lat_neg && (|acc_q[ACC_W-2:LAT_W]);
	assign lat_c     = lat_neg ? '0 : (lat_big ? LAT_MAX : acc_q[LAT_W-1:0]);
	assign step_last = (step_q == '0);
	assign rem_shift = {rem_q, acc_q[ACC_W-1]};

	// Operand selection for the shared adder.
	always_comb begin
		alu_req = '0;
		unique case (state_q)
			ST_SUBS: begin
				alu_req.a   = ACC_W'(obs_q.end_seconds);
				alu_req.b   = ACC_W'(obs_q.begin_seconds);
				alu_req.sub = 1'b1;
			end
			ST_MULK: begin
				alu_req.a = {acc_q[ACC_W-2:0], 1'b0};
				if (US_PER_S[step_q[US_IDX_W-1:0]]) begin
					alu_req.b = {{(ACC_W-DSEC_W){dsec_q[DSEC_W-1]}}, dsec_q};
				end
			end
			ST_ADDU: begin
				alu_req.a = acc_q;
				alu_req.b = ACC_W'(obs_q.end_micros);
			end
			ST_SUBU: begin
				alu_req.a   = acc_q;
				alu_req.b   = ACC_W'(obs_q.begin_micros);
				alu_req.sub = 1'b1;
			end
			ST_MULM: begin
				alu_req.a = {acc_q[ACC_W-2:0], 1'b0};
				if (mplier_q[step_q[CNT_IDX_W-1:0]]) begin
					alu_req.b = ACC_W'(mean_q);
				end
			end
			ST_ADDL: begin
				alu_req.a = acc_q;
				alu_req.b = ACC_W'({lat_q, {FRAC_W{1'b0}}});
			end
			ST_DIV: begin
				alu_req.a   = ACC_W'(rem_shift);
				alu_req.b   = ACC_W'(cnt_q);
				alu_req.sub = 1'b1;
			end
			ST_IDLE, ST_CLAMP, ST_FIN, ST_DONE: begin
				alu_req = '0;
			end
			default: begin
				alu_req = '0;
			end
		endcase
	end

	// Control state and the running statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
			cnt_q   <= '0;
			mean_q  <= '0;
			min_q   <= LAT_MAX;
			max_q   <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (obs_valid) begin
						state_q <= ST_SUBS;
					end
				end
				ST_SUBS: begin
					step_q  <= STEP_W'(US_W - 1);
					state_q <= ST_MULK;
				end
				ST_MULK: begin
					step_q <= step_q - 1'b1;
					if (step_last) begin
						state_q <= ST_ADDU;
					end
				end
				ST_ADDU: begin
					state_q <= ST_SUBU;
				end
				ST_SUBU: begin
					state_q <= ST_CLAMP;
				end
				ST_CLAMP: begin
					if (cnt_q != CNT_MAX) begin
						cnt_q <= cnt_q + 1'b1;
					end
					if (lat_c < min_q) begin
						min_q <= lat_c;
					end
					if (lat_c > max_q) begin
						max_q <= lat_c;
					end
					step_q  <= STEP_W'(CNT_W - 1);
					state_q <= ST_MULM;
				end
				ST_MULM: begin
					step_q <= step_q - 1'b1;
					if (step_last) begin
						state_q <= ST_ADDL;
					end
				end
				ST_ADDL: begin
					step_q  <= STEP_W'(ACC_W - 1);
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					step_q <= step_q - 1'b1;
					if (step_last) begin
						state_q <= ST_FIN;
					end
				end
				ST_FIN: begin
					// A quotient wider than the mean saturates.
					if (|acc_q[ACC_W-1:MEAN_W]) begin
						mean_q <= '1;
					end else begin
						mean_q <= acc_q[MEAN_W-1:0];
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (res_ready) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Working registers of the datapath.
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (obs_valid) begin
					obs_q <= obs;
				end
			end
			ST_SUBS: begin
				dsec_q <= alu_rsp.sum[DSEC_W-1:0];
				acc_q  <= '0;
			end
			ST_MULK, ST_ADDU, ST_SUBU, ST_MULM, ST_ADDL: begin
				acc_q <= alu_rsp.sum;
				if (state_q == ST_ADDL) begin
					rem_q <= '0;
				end
			end
			ST_CLAMP: begin
				lat_q    <= lat_c;
				back_q   <= lat_neg;
				clip_q   <= lat_big;
				acc_q    <= '0;
				mplier_q <= (cnt_q != CNT_MAX) ? cnt_q : CNT_MAX - 1'b1;
			end
			ST_DIV: begin
				// Restoring divide: one quotient bit enters at the bottom.
				acc_q <= {acc_q[ACC_W-2:0], alu_rsp.carry};
				if (alu_rsp.carry) begin
					rem_q <= alu_rsp.sum[REM_W-1:0];
				end else begin
					rem_q <= rem_shift[REM_W-1:0];
				end
			end
			ST_FIN, ST_DONE: begin
				acc_q <= acc_q;
			end
			default: begin
				acc_q <= acc_q;
			end
		endcase
	end

	// Result assembly.
	assign ready     = (state_q == ST_IDLE);
	assign res_valid = (state_q == ST_DONE);

	always_comb begin
		res.sample_latency    = lat_q;
		res.observation_count = cnt_q;
		res.mean_latency_q8   = mean_q;
		res.min_latency       = min_q;
		res.max_latency       = max_q;
		res.went_backwards    = back_q;
		res.clipped_high      = clip_q;
	end

`ifndef SYNTHESIS
	// The partial remainder always stays below the divisor.
	assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV) |-> (rem_q < cnt_q))
		else $error("lsa_seq: partial remainder not below divisor");

	// The observation count never goes down.
	assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q >= $past(cnt_q))
		else $error("lsa_seq: observation count decreased");

	// Once anything was seen, the minimum does not exceed the maximum.
	assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != '0) |-> (min_q <= max_q))
		else $error("lsa_seq: minimum above maximum");
`endif

endmodule

// ===== dv/latency_stats_accumulator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Latency statistics accumulator testbench
// Sends start/stop timestamp pairs through the observation channel, predicts
// each latency and the running count, mean, minimum and maximum in the bench,
// and checks every statistics transfer against the oldest prediction. Both
// channels see random idle gaps, one long output hold-off and drain pauses.
// ----------------------------------------------------------------------------
module latency_stats_accumulator_tb;
	import lsa_pkg::*;

	// One observation waiting to be sent, with the idle gap that follows it.
	typedef struct {
		obs_t obs;
		int   gap_after;
		bit   wait_drain;
	} obs_job_t;

	localparam logic [127:0] MEAN_LIMIT = (128'd1 << MEAN_W) - 128'd1;
	localparam longint       MICROS_PER_SECOND = 1000000;

	logic  clk = 1'b0;
	logic  arst_n = 1'b0;
	logic  obs_valid = 1'b0;
	logic  obs_stall;
	obs_t  obs_data = '0;
	logic  stat_valid;
	logic  stat_stall = 1'b0;
	stat_t stat_data;

	// Pending observations and the statistics they are expected to produce.
	obs_job_t obs_queue[$];
	stat_t    stats_expected[$];

	// Bench copy of the accumulator state.
	logic [CNT_W-1:0]  count_acc = '0;
	logic [MEAN_W-1:0] mean_acc = '0;
	logic [LAT_W-1:0]  min_acc = LAT_MAX;
	logic [LAT_W-1:0]  max_acc = '0;

	int mismatches = 0;

	// Sender state.
	int gap_left = 0;
	int cur_gap = 0;

	// Receiver state.
	int  stall_left = 0;
	int  free_left = 0;
	int  hold_left = 0;
	int  rx_seen = 0;
	int  cyc = 0;
	bit  hold_done = 1'b0;

	latency_stats_accumulator dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.obs_valid  (obs_valid),
		.obs_stall  (obs_stall),
		.obs_data   (obs_data),
		.stat_valid (stat_valid),
		.stat_stall (stat_stall),
		.stat_data  (stat_data)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	// Idle lengths: mostly none or short, now and then long.
	function automatic int draw_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 5);
		return $urandom_range(20, 90);
	endfunction

	// Fold one observation into the bench state and queue the statistics.
	function automatic void fold_observation(obs_t o);
		longint       bs, bu, es, eu, diff;
		logic [127:0] num, quo, prior, n128;
		stat_t        r;
		bs = o.begin_seconds;
		bu = o.begin_micros;
		es = o.end_seconds;
		eu = o.end_micros;
		diff = (es - bs) * MICROS_PER_SECOND + eu - bu;
		r = '0;
		if (diff < 0) begin
			r.sample_latency = '0;
			r.went_backwards = 1'b1;
		end else if (diff > longint'(LAT_MAX)) begin
			r.sample_latency = LAT_MAX;
			r.clipped_high = 1'b1;
		end else begin
			r.sample_latency = diff[LAT_W-1:0];
		end
		// The count saturates; the mean then keeps dividing by the top count.
		if (count_acc != CNT_MAX)
			count_acc = count_acc + 1'b1;
		n128 = count_acc;
		prior = mean_acc;
		num = prior * (n128 - 128'd1) + (128'(r.sample_latency) << FRAC_W);
		quo = num / n128;
		mean_acc = (quo > MEAN_LIMIT) ? MEAN_LIMIT[MEAN_W-1:0] : quo[MEAN_W-1:0];
		if (r.sample_latency < min_acc)
			min_acc = r.sample_latency;
		if (r.sample_latency > max_acc)
			max_acc = r.sample_latency;
		r.observation_count = count_acc;
		r.mean_latency_q8 = mean_acc;
		r.min_latency = min_acc;
		r.max_latency = max_acc;
		stats_expected.push_back(r);
	endfunction

	function automatic void check_field(string name, logic [63:0] want, logic [63:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, actual %0d", name, want, got);
			mismatches++;
		end
	endfunction

	task automatic add_obs(input logic [SEC_W-1:0] bs, input logic [US_W-1:0] bu,
			input logic [SEC_W-1:0] es, input logic [US_W-1:0] eu, input int gap,
			input bit drain);
		obs_job_t job;
		job.obs.begin_seconds = bs;
		job.obs.begin_micros = bu;
		job.obs.end_seconds = es;
		job.obs.end_micros = eu;
		job.gap_after = gap;
		job.wait_drain = drain;
		obs_queue.push_back(job);
	endtask

	// Sender: presents queued observations and predicts each one on transfer.
	always @(posedge clk or negedge arst_n) begin
		logic     accepted;
		logic     next_valid;
		obs_job_t job;
		if (!arst_n) begin
			obs_valid <= 1'b0;
			gap_left = 0;
		end else begin
			accepted = obs_valid && !obs_stall;
			if (accepted) begin
				fold_observation(obs_data);
				gap_left = cur_gap;
			end
			next_valid = obs_valid && !accepted;
			if (!next_valid && obs_queue.size() != 0) begin
				if (gap_left > 0) begin
					gap_left--;
				end else if (!(obs_queue[0].wait_drain && stats_expected.size() != 0)) begin
					job = obs_queue.pop_front();
					obs_data <= job.obs;
					cur_gap = job.gap_after;
					next_valid = 1'b1;
				end
			end
			obs_valid <= next_valid;
		end
	end

	// Receiver stall: random bursts, quiet windows, and one long hold-off.
	always @(posedge clk or negedge arst_n) begin
		logic next_stall;
		if (!arst_n) begin
			stat_stall <= 1'b0;
		end else begin
			cyc++;
			if (stat_valid && !stat_stall)
				rx_seen++;
			if (rx_seen >= 40 && !hold_done) begin
				hold_left = 1500;
				hold_done = 1'b1;
			end
			if (hold_left > 0) begin
				hold_left--;
				next_stall = 1'b1;
			end else if ((cyc / 3000) % 3 == 1) begin
				next_stall = 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				next_stall = 1'b1;
			end else if (free_left > 0) begin
				free_left--;
				next_stall = 1'b0;
			end else begin
				stall_left = draw_gap();
				free_left = $urandom_range(1, 30);
				next_stall = 1'b0;
			end
			stat_stall <= next_stall;
		end
	end

	// Monitor: each statistics transfer is matched with the oldest prediction.
	always @(posedge clk) begin
		stat_t want;
		if (arst_n && stat_valid && !stat_stall) begin
			if (stats_expected.size() == 0) begin
				$error("statistics transfer with no observation outstanding");
				mismatches++;
			end else begin
				want = stats_expected.pop_front();
				check_field("sample_latency", want.sample_latency, stat_data.sample_latency);
				check_field("observation_count", want.observation_count,
					stat_data.observation_count);
				check_field("mean_latency_q8", want.mean_latency_q8, stat_data.mean_latency_q8);
				check_field("min_latency", want.min_latency, stat_data.min_latency);
				check_field("max_latency", want.max_latency, stat_data.max_latency);
				check_field("went_backwards", want.went_backwards, stat_data.went_backwards);
				check_field("clipped_high", want.clipped_high, stat_data.clipped_high);
			end
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [SEC_W-1:0] bs, es;
		logic [US_W-1:0]  bu, eu;
		int               kind;
		int               gap;

		// Directed: zero, extremes, range edges, backwards and oversized latencies.
		add_obs(32'd0, 20'd0, 32'd1, 20'd500000, 0, 1'b0);
		add_obs(32'd0, 20'd0, 32'd0, 20'd0, 0, 1'b0);
		add_obs('1, 20'd999999, '1, 20'd999999, 0, 1'b0);
		add_obs(32'd0, 20'd1, 32'd0, 20'd0, 3, 1'b0);
		add_obs('1, 20'd0, 32'd0, 20'd0, 0, 1'b0);
		add_obs(32'd0, 20'd0, 32'd281474976, 20'd710655, 0, 1'b0);
		add_obs(32'd0, 20'd0, 32'd281474976, 20'd710656, 1, 1'b0);
		add_obs(32'd0, 20'd0, '1, '1, 0, 1'b0);
		add_obs(32'd5, '1, 32'd7, 20'd0, 0, 1'b0);
		add_obs(32'd3, 20'd0, 32'd3, '1, 2, 1'b0);
		add_obs(32'd10, 20'd999999, 32'd11, 20'd0, 0, 1'b0);
		add_obs(32'd0, '1, 32'd0, 20'd0, 0, 1'b0);
		add_obs(32'd1000, 20'd0, 32'd281475976, 20'd0, 0, 1'b0);
		add_obs('1, '1, '1, '1, 0, 1'b0);
		add_obs(32'd0, 20'd0, '1, 20'd0, 0, 1'b0);
		add_obs(32'h8000_0000, 20'h80000, 32'h8000_0000, 20'h80001, 0, 1'b0);
		add_obs(32'd7, 20'd123456, 32'd9, 20'd654321, 0, 1'b0);
		add_obs(32'd42, 20'd0, 32'd41, '1, 0, 1'b0);

		// Random: mostly realistic intervals, with edges and noise mixed in.
		for (int i = 0; i < 400; i++) begin
			kind = $urandom_range(0, 99);
			bs = $urandom;
			bu = $urandom_range(0, 999999);
			eu = $urandom_range(0, 999999);
			if (kind < 55) begin
				es = bs + (($urandom_range(0, 3) == 0) ? $urandom_range(0, 100000)
					: $urandom_range(0, 3));
			end else if (kind < 70) begin
				bu = $urandom_range(0, (1 << US_W) - 1);
				eu = $urandom_range(0, (1 << US_W) - 1);
				es = bs + $urandom_range(0, 2);
			end else if (kind < 80) begin
				bu = $urandom_range(0, (1 << US_W) - 1);
				eu = $urandom_range(0, (1 << US_W) - 1);
				es = $urandom;
			end else if (kind < 90) begin
				es = bs + 32'd281474975 + $urandom_range(0, 2);
			end else begin
				es = bs;
				eu = $urandom_range(0, bu);
			end
			// A stretch with no sender gaps; pauses for a full drain twice.
			gap = (i >= 120 && i < 180) ? 0 : draw_gap();
			add_obs(bs, bu, es, eu, gap, (i == 0 || i == 250));
		end

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		while (obs_queue.size() != 0 || obs_valid)
			@(negedge clk);
		while (stats_expected.size() != 0)
			@(negedge clk);
		repeat (300) @(negedge clk);
		if (mismatches == 0 && stats_expected.size() == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	// Watchdog.
	initial begin
		#1200000;
		$display("simulation failed");
		$finish;
	end

endmodule
